/* design/hci_pkg.sv */
// ----------------------------------------------------------------------------
// hci_pkg: shared types and constants of the Hilbert curve index block
// Widths of the fixed-point datapath, register indexes, reset values and the
// per-level working item that travels down the level pipeline.
// ----------------------------------------------------------------------------
package hci_pkg;

	// Q16.16 coordinates and axis components.
	localparam int unsigned COORD_W = 32;
	// The working centre moves by at most twice the initial half extent in total.
	localparam int unsigned CENTRE_W = 34;
	// Point minus centre.
	localparam int unsigned DIFF_W = 35;
	// One exact product and the exact sum of two products.
	localparam int unsigned PROD_W = 67;
	localparam int unsigned SUM_W = 68;

	// Result width and the bit position of the first level's quadrant.
	localparam int unsigned INDEX_W = 32;
	localparam int unsigned TOP_SHIFT = 30;
	localparam int unsigned MAX_LEVELS = 16;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RED_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RED_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_Y = 3'd5;

	// Reset values: unit square around the origin.
	localparam logic signed [COORD_W-1:0] RST_ORIGIN = 32'sd0;
	localparam logic signed [COORD_W-1:0] RST_AXIS_ONE = 32'sd65536;
	localparam logic signed [COORD_W-1:0] RST_AXIS_ZERO = 32'sd0;

	// Quadrant codes.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Working item of one point between levels.
	typedef struct packed {
		logic signed [COORD_W-1:0]  px;
		logic signed [COORD_W-1:0]  py;
		logic signed [CENTRE_W-1:0] cx;
		logic signed [CENTRE_W-1:0] cy;
		logic signed [COORD_W-1:0]  rx;
		logic signed [COORD_W-1:0]  ry;
		logic signed [COORD_W-1:0]  bx;
		logic signed [COORD_W-1:0]  by;
		logic [INDEX_W-1:0]         idx;
	} item_t;

endpackage

/* design/hci_level.sv */
// ----------------------------------------------------------------------------
// hci_level: one level of the Hilbert subdivision
// Three register stages: offset from the centre, the four projection
// products, then the sign tests, quadrant choice and update of centre/axes.
// ----------------------------------------------------------------------------
module hci_level #(
	parameter int unsigned IDX_SHIFT = 30
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  hci_pkg::item_t in_item,
	output logic           out_valid,
	output hci_pkg::item_t out_item
);

	localparam int unsigned CW = hci_pkg::COORD_W;
	localparam int unsigned NW = hci_pkg::CENTRE_W;
	localparam int unsigned DW = hci_pkg::DIFF_W;
	localparam int unsigned PW = hci_pkg::PROD_W;
	localparam int unsigned SW = hci_pkg::SUM_W;

	logic valid_s1, valid_s2, valid_s3;
	hci_pkg::item_t item_s1, item_s2, item_s3;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] prx_s2, pry_s2, pbx_s2, pby_s2;

	logic signed [DW-1:0] dx_c, dy_c;
	logic signed [SW-1:0] sum_r, sum_b;
	logic r_pos, b_pos, b_neg;
	logic [1:0] quad;
	logic signed [CW-1:0] hrx, hry, hbx, hby;
	logic signed [NW-1:0] ex_rx, ex_ry, ex_bx, ex_by;
	hci_pkg::item_t nxt;

	// Offset of the point from the working centre.
	assign dx_c = DW'($signed(in_item.px)) - DW'($signed(in_item.cx));
	assign dy_c = DW'($signed(in_item.py)) - DW'($signed(in_item.cy));

	// Exact projection sums; only their signs matter.
	assign sum_r = SW'(prx_s2) + SW'(pry_s2);
	assign sum_b = SW'(pbx_s2) + SW'(pby_s2);
	assign r_pos = !sum_r[SW-1] && (sum_r != '0);
	assign b_pos = !sum_b[SW-1] && (sum_b != '0);
	assign b_neg = sum_b[SW-1];

	// Halved axes, rounding toward minus infinity.
	assign hrx = $signed(item_s2.rx) >>> 1;
	assign hry = $signed(item_s2.ry) >>> 1;
	assign hbx = $signed(item_s2.bx) >>> 1;
	assign hby = $signed(item_s2.by) >>> 1;
	assign ex_rx = NW'(hrx);
	assign ex_ry = NW'(hry);
	assign ex_bx = NW'(hbx);
	assign ex_by = NW'(hby);

	// Quadrant choice; a zero projection counts as not positive first.
	always_comb begin
		nxt = item_s2;
		nxt.rx = hrx;
		nxt.ry = hry;
		nxt.bx = hbx;
		nxt.by = hby;
		priority if (!r_pos && !b_pos) begin
			quad = hci_pkg::QUAD_0;
			nxt.cx = item_s2.cx - (ex_bx + ex_rx);
			nxt.cy = item_s2.cy - (ex_by + ex_ry);
			nxt.rx = hbx;
			nxt.ry = hby;
			nxt.bx = hrx;
			nxt.by = hry;
		end else if (!r_pos) begin
			quad = hci_pkg::QUAD_1;
			nxt.cx = item_s2.cx + (ex_bx - ex_rx);
			nxt.cy = item_s2.cy + (ex_by - ex_ry);
		end else if (!b_neg) begin
			quad = hci_pkg::QUAD_2;
			nxt.cx = item_s2.cx + (ex_bx + ex_rx);
			nxt.cy = item_s2.cy + (ex_by + ex_ry);
		end else begin
			quad = hci_pkg::QUAD_3;
			nxt.cx = item_s2.cx + (ex_rx - ex_bx);
			nxt.cy = item_s2.cy + (ex_ry - ex_by);
			nxt.rx = -hbx;
			nxt.ry = -hby;
			nxt.bx = -hrx;
			nxt.by = -hry;
		end
		nxt.idx = item_s2.idx | (hci_pkg::INDEX_W'(quad) << IDX_SHIFT);
	end

	// Valid bits advance with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload registers of the three stages.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			item_s2 <= item_s1;
			prx_s2 <= PW'(dx_s1) * PW'($signed(item_s1.rx));
			pry_s2 <= PW'(dy_s1) * PW'($signed(item_s1.ry));
			pbx_s2 <= PW'(dx_s1) * PW'($signed(item_s1.bx));
			pby_s2 <= PW'(dy_s1) * PW'($signed(item_s1.by));
			item_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_item = item_s3;

endmodule

/* design/hci_out_buf.sv */
// ----------------------------------------------------------------------------
// hci_out_buf: two-entry output buffer
// Holds finished indexes for the result channel and tells the pipeline
// whether it may advance, from a registered count only.
// ----------------------------------------------------------------------------
module hci_out_buf (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [hci_pkg::INDEX_W-1:0]  push_data,
	output logic                         room,
	output logic                         tvalid,
	input  logic                         tready,
	output logic [hci_pkg::INDEX_W-1:0]  tdata
);

	logic [1:0] count_q;
	logic [hci_pkg::INDEX_W-1:0] head_q, tail_q;
	logic pop;

	assign pop = tvalid && tready;
	assign tvalid = (count_q != 2'd0);
	assign room = (count_q != 2'd2);
	assign tdata = head_q;

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Entry data: the head is what the channel shows.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && (count_q == 2'd1)) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
			end
			if (push) begin
				tail_q <= push_data;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end
	end

endmodule

/* design/hilbert_curve_index.sv */
// ----------------------------------------------------------------------------
// hilbert_curve_index: 2D Hilbert curve index of a point in a configured box
// A chain of LEVELS level units (at most MAX_LEVELS), each three stages
// deep, followed by a two-entry output buffer.
//
//   channel  | dir | contents
//   s_axis   | in  | tdata[31:0] point_x, tdata[63:32] point_y
//   m_axis   | out | tdata[31:0] curve_index
//   cfg      | in  | cfg_we, cfg_index (0..5), cfg_wdata
//
// One point enters per cycle while the output buffer has room and passes
// the three stages of each level (offset, multiply, sign test and update).
// arst_n clears the valid bits, the buffer count and the box to the unit
// square around the origin. When the output buffer holds two results the
// whole level chain stalls and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module hilbert_curve_index #(
	parameter int unsigned LEVELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] curve_index
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned CW = hci_pkg::COORD_W;
	localparam int unsigned NW = hci_pkg::CENTRE_W;
	// Level counts above the index capacity act as the full depth.
	localparam int unsigned NUM_LEVELS =
		(LEVELS > hci_pkg::MAX_LEVELS) ? hci_pkg::MAX_LEVELS : LEVELS;

	logic signed [CW-1:0] origin_x_q, origin_y_q;
	logic signed [CW-1:0] red_x_q, red_y_q, blue_x_q, blue_y_q;
	logic en;
	logic lvl_valid [0:NUM_LEVELS];
	hci_pkg::item_t lvl_item [0:NUM_LEVELS];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= hci_pkg::RST_ORIGIN;
			origin_y_q <= hci_pkg::RST_ORIGIN;
			red_x_q <= hci_pkg::RST_AXIS_ONE;
			red_y_q <= hci_pkg::RST_AXIS_ZERO;
			blue_x_q <= hci_pkg::RST_AXIS_ZERO;
			blue_y_q <= hci_pkg::RST_AXIS_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hci_pkg::REG_ORIGIN_X: origin_x_q <= cfg_wdata;
				hci_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				hci_pkg::REG_RED_X: red_x_q <= cfg_wdata;
				hci_pkg::REG_RED_Y: red_y_q <= cfg_wdata;
				hci_pkg::REG_BLUE_X: blue_x_q <= cfg_wdata;
				hci_pkg::REG_BLUE_Y: blue_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline advances whenever the output buffer has a free entry.
	assign s_axis_tready = en;

	// Entry item: the point with a fresh copy of the box.
	always_comb begin
		lvl_valid[0] = s_axis_tvalid;
		lvl_item[0].px = s_axis_tdata[31:0];
		lvl_item[0].py = s_axis_tdata[63:32];
		lvl_item[0].cx = NW'(origin_x_q);
		lvl_item[0].cy = NW'(origin_y_q);
		lvl_item[0].rx = red_x_q;
		lvl_item[0].ry = red_y_q;
		lvl_item[0].bx = blue_x_q;
		lvl_item[0].by = blue_y_q;
		lvl_item[0].idx = '0;
	end

	// One unit per level; level g writes its quadrant two bits lower than g-1.
	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
		hci_level #(
			.IDX_SHIFT(hci_pkg::TOP_SHIFT - 2 * g)
		) u_level (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(lvl_valid[g]),
			.in_item(lvl_item[g]),
			.out_valid(lvl_valid[g+1]),
			.out_item(lvl_item[g+1])
		);
	end

	// Output buffer toward the result channel.
	hci_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(en && lvl_valid[NUM_LEVELS]),
		.push_data(lvl_item[NUM_LEVELS].idx),
		.room(en),
		.tvalid(m_axis_tvalid),
		.tready(m_axis_tready),
		.tdata(m_axis_tdata)
	);

`ifndef NO_ASSERTIONS
	// A stalled chain keeps its last stage unchanged.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> $stable(lvl_valid[NUM_LEVELS]))
		else $error("level chain moved while stalled");

	// An empty output buffer never blocks the input.
	a_empty_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with an empty output buffer");

	// A full buffer with a result waiting keeps offering results.
	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_valid[NUM_LEVELS] && !s_axis_tready) |=> m_axis_tvalid)
		else $error("full output buffer lost its results");
`endif

endmodule

/* test/hilbert_index_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_index_checker: result checker for the Hilbert curve index block
// Watches the point, result and register write channels. It keeps its own
// copy of the box registers and computes the expected curve index of every
// point transfer. Each result transfer is compared with the oldest pending
// index. The failure count and the number of pending indexes go to the top.
// ----------------------------------------------------------------------------
module hilbert_index_checker #(
	parameter int unsigned LEVELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [31:0] curve_index
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          errors,
	output int          pending
);

	// Local copy of the box registers.
	logic signed [hci_pkg::COORD_W-1:0] box_ox, box_oy, box_rx, box_ry, box_bx, box_by;

	// Curve indexes of accepted points, oldest first.
	logic [hci_pkg::INDEX_W-1:0] index_queue[$];

	// Side of an axis a point offset lies on: -1, 0 or +1, from the exact
	// sum of the two products.
	function automatic int axis_side(input longint dx, dy, ax, ay);
		logic signed [127:0] wdx, wdy, wax, way, sum;
		wdx = dx;
		wdy = dy;
		wax = ax;
		way = ay;
		sum = wdx * wax + wdy * way;
		if (sum < 0)
			return -1;
		if (sum == 0)
			return 0;
		return 1;
	endfunction

	// Walk the levels of the curve for one point in the current box.
	function automatic logic [hci_pkg::INDEX_W-1:0] hilbert_index(
			input logic signed [hci_pkg::COORD_W-1:0] x,
			input logic signed [hci_pkg::COORD_W-1:0] y);
		longint px, py, cx, cy, rx, ry, bx, by, t;
		int sr, sb, lvl;
		logic [1:0] quad;
		logic [hci_pkg::INDEX_W-1:0] idx;
		px = x;
		py = y;
		cx = box_ox;
		cy = box_oy;
		rx = box_rx;
		ry = box_ry;
		bx = box_bx;
		by = box_by;
		idx = '0;
		for (lvl = 0; lvl < LEVELS && lvl < hci_pkg::MAX_LEVELS; lvl++) begin
			sr = axis_side(px - cx, py - cy, rx, ry);
			sb = axis_side(px - cx, py - cy, bx, by);
			// Halving rounds toward minus infinity.
			rx = rx >>> 1;
			ry = ry >>> 1;
			bx = bx >>> 1;
			by = by >>> 1;
			// Zero counts as the lower side, but zero blue as upper once red is positive.
			if (sr <= 0 && sb <= 0) begin
				quad = hci_pkg::QUAD_0;
				cx = cx - (bx + rx);
				cy = cy - (by + ry);
				t = rx; rx = bx; bx = t;
				t = ry; ry = by; by = t;
			end else if (sr <= 0) begin
				quad = hci_pkg::QUAD_1;
				cx = cx + bx - rx;
				cy = cy + by - ry;
			end else if (sb >= 0) begin
				quad = hci_pkg::QUAD_2;
				cx = cx + bx + rx;
				cy = cy + by + ry;
			end else begin
				quad = hci_pkg::QUAD_3;
				cx = cx + rx - bx;
				cy = cy + ry - by;
				t = rx; rx = -bx; bx = -t;
				t = ry; ry = -by; by = -t;
			end
			idx = idx + (32'(quad) << (hci_pkg::TOP_SHIFT - 2 * lvl));
		end
		return idx;
	endfunction

	// Track register writes, predict on point transfers, compare on result transfers.
	always @(posedge clk or negedge arst_n) begin
		int fails_now;
		logic [hci_pkg::INDEX_W-1:0] want;
		if (!arst_n) begin
			index_queue.delete();
			errors <= 0;
			pending <= 0;
			box_ox <= hci_pkg::RST_ORIGIN;
			box_oy <= hci_pkg::RST_ORIGIN;
			box_rx <= hci_pkg::RST_AXIS_ONE;
			box_ry <= hci_pkg::RST_AXIS_ZERO;
			box_bx <= hci_pkg::RST_AXIS_ZERO;
			box_by <= hci_pkg::RST_AXIS_ONE;
		end else begin
			fails_now = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (index_queue.size() == 0) begin
					$display("%0t: curve_index %h arrived with nothing expected",
						$time, m_axis_tdata);
					fails_now = fails_now + 1;
				end else begin
					want = index_queue.pop_front();
					if (m_axis_tdata !== want) begin
						$display("%0t: curve_index mismatch, expected %h, actual %h",
							$time, want, m_axis_tdata);
						fails_now = fails_now + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				index_queue.push_back(hilbert_index(s_axis_tdata[31:0], s_axis_tdata[63:32]));
			// Indexes outside the register list are ignored.
			if (cfg_we) begin
				case (cfg_index)
					hci_pkg::REG_ORIGIN_X: box_ox <= cfg_wdata;
					hci_pkg::REG_ORIGIN_Y: box_oy <= cfg_wdata;
					hci_pkg::REG_RED_X: box_rx <= cfg_wdata;
					hci_pkg::REG_RED_Y: box_ry <= cfg_wdata;
					hci_pkg::REG_BLUE_X: box_bx <= cfg_wdata;
					hci_pkg::REG_BLUE_Y: box_by <= cfg_wdata;
					default: ;
				endcase
			end
			errors <= errors + fails_now;
			pending <= index_queue.size();
		end
	end

endmodule

/* test/hilbert_curve_index_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_curve_index_tb: testbench of the Hilbert curve index block
// Drives points through a series of boxes: the reset box with directed
// points on the axes and at the coordinate extremes, then random points
// mostly inside each box, on a grid of tie points, anywhere, or at the
// extremes. Both stream sides idle at random, with one phase at full rate.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hilbert_curve_index_tb;

	localparam int unsigned LEVELS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int COORD_MAX = 32'sh7FFFFFFF;
	localparam int COORD_MIN = 32'sh80000000;
	localparam int HALF = 32768;
	localparam int ONE = 65536;
	// Register indexes past the end of the list.
	localparam logic [hci_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [hci_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [31:0] point_x, [63:32] point_y
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] curve_index
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	int fail_count;
	int pending_count;
	int cycles = 0;
	bit steady = 1'b0;
	// Box as last written, used only to aim the random points.
	int box[6];

	hilbert_curve_index #(
		.LEVELS(LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	hilbert_index_checker #(
		.LEVELS(LEVELS)
	) index_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(fail_count),
		.pending(pending_count)
	);

	// 50 MHz clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side stalls in about a third of the cycles unless running at full rate.
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
	end

	// Cycle limit in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// One point transfer, after a random gap.
	task automatic send_point(input logic [31:0] x, input logic [31:0] y);
		while (!steady && $urandom_range(0, 99) < 32) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {$urandom, $urandom};
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Register write; the enable stays high for back-to-back writes.
	task automatic write_reg(input logic [hci_pkg::REG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// Write the whole box, with ignored writes to the spare indexes around it.
	task automatic load_box(input int ox, input int oy, input int rx, input int ry,
			input int bx, input int by);
		box[hci_pkg::REG_ORIGIN_X] = ox;
		box[hci_pkg::REG_ORIGIN_Y] = oy;
		box[hci_pkg::REG_RED_X] = rx;
		box[hci_pkg::REG_RED_Y] = ry;
		box[hci_pkg::REG_BLUE_X] = bx;
		box[hci_pkg::REG_BLUE_Y] = by;
		write_reg(REG_SPARE_A, $urandom);
		write_reg(hci_pkg::REG_ORIGIN_X, ox);
		write_reg(hci_pkg::REG_ORIGIN_Y, oy);
		write_reg(hci_pkg::REG_RED_X, rx);
		write_reg(hci_pkg::REG_RED_Y, ry);
		write_reg(hci_pkg::REG_BLUE_X, bx);
		write_reg(hci_pkg::REG_BLUE_Y, by);
		write_reg(REG_SPARE_B, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Stop sending and wait until every result is back.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random value with a random scale, so that small and large boxes both occur.
	function automatic int scaled_random();
		return int'($urandom) >>> $urandom_range(0, 24);
	endfunction

	// A coordinate from the extremes of the field, near zero, or the box centre.
	function automatic int extreme_coord(input int centre);
		case ($urandom_range(0, 5))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return centre;
		endcase
	endfunction

	// Random points: mostly inside the box, some on a tie grid, anywhere or extreme.
	task automatic random_points(input int count);
		longint s, t, gx, gy;
		int pick, n;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				s = longint'($urandom_range(0, 2 * ONE)) - ONE;
				t = longint'($urandom_range(0, 2 * ONE)) - ONE;
			end else begin
				s = (longint'($urandom_range(0, 16)) - 8) * 8192;
				t = (longint'($urandom_range(0, 16)) - 8) * 8192;
			end
			if (pick < 75) begin
				gx = longint'(box[hci_pkg::REG_ORIGIN_X])
					+ ((s * box[hci_pkg::REG_RED_X] + t * box[hci_pkg::REG_BLUE_X]) >>> 16);
				gy = longint'(box[hci_pkg::REG_ORIGIN_Y])
					+ ((s * box[hci_pkg::REG_RED_Y] + t * box[hci_pkg::REG_BLUE_Y]) >>> 16);
			end else if (pick < 90) begin
				gx = int'($urandom);
				gy = int'($urandom);
			end else begin
				gx = extreme_coord(box[hci_pkg::REG_ORIGIN_X]);
				gy = extreme_coord(box[hci_pkg::REG_ORIGIN_Y]);
			end
			send_point(gx[31:0], gy[31:0]);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int n, a, b;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		box[hci_pkg::REG_ORIGIN_X] = hci_pkg::RST_ORIGIN;
		box[hci_pkg::REG_ORIGIN_Y] = hci_pkg::RST_ORIGIN;
		box[hci_pkg::REG_RED_X] = hci_pkg::RST_AXIS_ONE;
		box[hci_pkg::REG_RED_Y] = hci_pkg::RST_AXIS_ZERO;
		box[hci_pkg::REG_BLUE_X] = hci_pkg::RST_AXIS_ZERO;
		box[hci_pkg::REG_BLUE_Y] = hci_pkg::RST_AXIS_ONE;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset box: ties on the axes, each quadrant, corners and field extremes.
		send_point(0, 0);
		send_point(0, -HALF);
		send_point(0, HALF);
		send_point(HALF, 0);
		send_point(HALF, -HALF);
		send_point(-HALF, -HALF);
		send_point(-HALF, HALF);
		send_point(HALF, HALF);
		send_point(ONE, ONE);
		send_point(-ONE, ONE);
		send_point(COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN);
		send_point(COORD_MAX, COORD_MIN);
		send_point(COORD_MIN, COORD_MAX);
		send_point(-1, -1);
		send_point(1, 1);
		random_points(150);
		wait_idle();

		// Large square box at full rate on both sides.
		load_box(0, 0, 1 << 30, 0, 0, 1 << 30);
		steady <= 1'b1;
		random_points(150);
		wait_idle();
		steady <= 1'b0;

		// Register extremes.
		load_box(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		random_points(150);
		wait_idle();
		load_box(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
		random_points(150);
		wait_idle();

		// Degenerate box: every projection is zero.
		load_box(scaled_random(), scaled_random(), 0, 0, 0, 0);
		random_points(100);
		wait_idle();

		// Rotated square box.
		a = int'($urandom) >>> $urandom_range(8, 20);
		b = int'($urandom) >>> $urandom_range(8, 20);
		load_box(scaled_random(), scaled_random(), a, b, -b, a);
		random_points(150);
		wait_idle();

		// Arbitrary skewed boxes.
		for (n = 0; n < 5; n++) begin
			load_box(scaled_random(), scaled_random(), scaled_random(), scaled_random(),
				scaled_random(), scaled_random());
			random_points(140);
			wait_idle();
		end

		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
